// ----- rtl/fsc_pkg.sv -----
// Shared types, codes and range tables of the formant slot classifier.
`timescale 1ns / 1ps

package fsc_pkg;

   // default slot capacity and the hard limit of one frame
   localparam int MAX_SLOTS_DEFAULT = 8;
   localparam int SLOT_HARD_CAP     = 8;

   // configuration register indexes
   localparam logic [1:0] CSR_SOURCE_CLASS   = 2'd0;
   localparam logic [1:0] CSR_BIN_RESOLUTION = 2'd1;
   localparam logic [1:0] CSR_MAX_FORMANTS   = 2'd2;

   // configuration reset values
   localparam logic [2:0]  SOURCE_CLASS_RESET   = 3'd0;
   localparam logic [15:0] BIN_RESOLUTION_RESET = 16'd2560;
   localparam logic [3:0]  MAX_FORMANTS_RESET   = 4'd4;

   // power value of results that carry no power
   localparam logic signed [19:0] POWER_FLOOR = 20'sh80000;

   typedef enum logic [1:0] {
      OP_START  = 2'd0,
      OP_BUMP   = 2'd1,
      OP_END    = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_PITCH     = 3'd0,
      ST_FOUND     = 3'd1,
      ST_NOT_AVAIL = 3'd2,
      ST_UNDEFINED = 3'd3,
      ST_MAG_ERROR = 3'd4,
      ST_DONE      = 3'd5
   } status_type;

   typedef struct packed {
      op_type             op;
      logic [13:0]        pitch_hz;
      logic [15:0]        bump_distance;
      logic signed [15:0] bump_amplitude;
   } req_payload_type;

   typedef struct packed {
      logic [3:0]         slot_index;
      logic [19:0]        frequency_hz;
      logic signed [19:0] power_db;
      status_type         status;
      logic [3:0]         formant_count;
      logic               last;
   } rsp_payload_type;

   typedef struct packed {
      logic [19:0] lo;
      logic [19:0] hi;
   } range_type;

   // range limits in Hz, [slot][source class]
   localparam logic [12:0] RANGE_LO_HZ [0:4][0:4] = '{
      '{13'd50,   13'd50,   13'd200,  13'd350,  13'd50},
      '{13'd100,  13'd100,  13'd300,  13'd400,  13'd500},
      '{13'd700,  13'd700,  13'd800,  13'd1000, 13'd1500},
      '{13'd1600, 13'd1600, 13'd1800, 13'd2700, 13'd2500},
      '{13'd3000, 13'd2700, 13'd3200, 13'd3500, 13'd3500}
   };
   localparam logic [12:0] RANGE_HI_HZ [0:4][0:4] = '{
      '{13'd500,  13'd200,  13'd350,  13'd500,  13'd500},
      '{13'd1100, 13'd900,  13'd900,  13'd1100, 13'd1500},
      '{13'd3100, 13'd2200, 13'd2700, 13'd3000, 13'd2500},
      '{13'd4000, 13'd3200, 13'd3500, 13'd4000, 13'd3500},
      '{13'd5000, 13'd3900, 13'd4500, 13'd4800, 13'd4500}
   };

   // open range of a slot in Hz Q18.2; slots above four use 0.85 and 1.5 of nominal
   function automatic range_type slot_range(input logic [3:0] slot, input logic [2:0] src);
      logic [2:0] col;
      range_type  r;
      col = (src > 3'd4) ? 3'd0 : src;
      r   = '0;
      if (slot <= 4'd4) begin
         r.lo = {5'd0, RANGE_LO_HZ[slot[2:0]][col], 2'b00};
         r.hi = {5'd0, RANGE_HI_HZ[slot[2:0]][col], 2'b00};
      end else begin
         case (slot)
            4'd5: begin
               r.lo = 20'd15300;
               r.hi = 20'd27000;
            end
            4'd6: begin
               r.lo = 20'd18700;
               r.hi = 20'd33000;
            end
            4'd7: begin
               r.lo = 20'd22100;
               r.hi = 20'd39000;
            end
            4'd8: begin
               r.lo = 20'd25500;
               r.hi = 20'd45000;
            end
            default: r = '0;
         endcase
      end
      return r;
   endfunction

endpackage

// ----- rtl/formant_slot_classifier.sv -----
// Top level of the formant slot classifier: control store, sequencer and datapath.
`timescale 1ns / 1ps

// Formant slot classifier. A start transfer passes the fetch and start steps and emits the
// pitch result; a bump transfer passes the transfer, multiply and range lookup, and classify
// steps and emits at most one result; an end transfer takes the end step, then one fill
// step for each unfilled slot and one for the done result, or emits nothing if aborted.
// The step counter walks a small control store one word per cycle and holds on a step
// that emits while the output register is still full, and on the fetch step while no
// input is valid. New input is taken only on the fetch step. Configuration writes take
// effect at once and are meant for idle periods between frames.
module formant_slot_classifier
   import fsc_pkg::*;
#(
   parameter int MAX_SLOTS = MAX_SLOTS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            csr_write_en,
   input  logic [1:0]      csr_index,
   input  logic [15:0]     csr_wdata
);

   localparam logic [3:0] SLOT_CAP =
      4'((MAX_SLOTS < SLOT_HARD_CAP) ? MAX_SLOTS : SLOT_HARD_CAP);

   // program addresses
   localparam logic [2:0] S_FETCH    = 3'd0;
   localparam logic [2:0] S_START    = 3'd1;
   localparam logic [2:0] S_PREP     = 3'd2;
   localparam logic [2:0] S_END      = 3'd3;
   localparam logic [2:0] S_NOP      = 3'd4;
   localparam logic [2:0] S_CLASSIFY = 3'd5;
   localparam logic [2:0] S_FILL     = 3'd6;

   typedef enum logic [2:0] {
      A_NONE, A_ACCEPT, A_PITCH, A_PREP, A_CLASSIFY, A_LOOP_INIT, A_FILL
   } act_type;

   typedef enum logic [2:0] {
      C_ALWAYS, C_DISPATCH, C_SKIP_BUMP, C_ABORTED, C_FILL_DONE
   } cond_type;

   typedef struct packed {
      act_type    act;
      cond_type   cond;
      logic [2:0] jmp_t;
      logic [2:0] jmp_f;
   } ctl_word_type;

   // control store: action, jump condition, target when true, target when false
   function automatic ctl_word_type ucode(input logic [2:0] addr);
      ctl_word_type w;
      case (addr)
         S_FETCH:    w = '{A_ACCEPT,    C_DISPATCH,  S_FETCH, S_FETCH};
         S_START:    w = '{A_PITCH,     C_ALWAYS,    S_FETCH, S_FETCH};
         S_PREP:     w = '{A_PREP,      C_SKIP_BUMP, S_FETCH, S_CLASSIFY};
         S_END:      w = '{A_LOOP_INIT, C_ABORTED,   S_FETCH, S_FILL};
         S_NOP:      w = '{A_NONE,      C_ALWAYS,    S_FETCH, S_FETCH};
         S_CLASSIFY: w = '{A_CLASSIFY,  C_ALWAYS,    S_FETCH, S_FETCH};
         S_FILL:     w = '{A_FILL,      C_FILL_DONE, S_FETCH, S_FILL};
         default:    w = '{A_NONE,      C_ALWAYS,    S_FETCH, S_FETCH};
      endcase
      return w;
   endfunction

   logic [2:0]      step_ff, step_in;
   logic [2:0]      source_class_ff;
   logic [15:0]     bin_res_ff;
   logic [3:0]      max_formants_ff;
   logic [3:0]      filled_ff, filled_in;
   logic            aborted_ff, aborted_in;
   logic [3:0]      slot_ctr_ff, slot_ctr_in;
   req_payload_type req_ff, req_in;
   logic [31:0]     prod_ff, prod_in;
   logic [19:0]     lo_ff, lo_in;
   logic [19:0]     hi_ff, hi_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   ctl_word_type       ctl;
   logic [3:0]         lim;
   logic [3:0]         next_slot;
   logic               emits;
   logic               out_free;
   logic               hold;
   logic               cond_true;
   logic [2:0]         dispatch_target;
   logic               fire;
   logic [19:0]        freq;
   logic signed [19:0] amp_wide;
   logic signed [19:0] power;
   range_type          rng;

   assign ctl       = ucode(step_ff);
   assign lim       = (max_formants_ff > SLOT_CAP) ? SLOT_CAP : max_formants_ff;
   assign next_slot = filled_ff + 4'd1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emits     = ctl.act inside {A_PITCH, A_CLASSIFY, A_FILL};
   assign hold      = ((ctl.act == A_ACCEPT) && !req_valid) || (emits && !out_free);
   assign freq      = prod_ff[31:12];
   assign amp_wide  = {{4{req_ff.bump_amplitude[15]}}, req_ff.bump_amplitude};
   assign power     = (amp_wide <<< 3) + (amp_wide <<< 1);
   assign rng       = slot_range(next_slot, source_class_ff);

   // decode the op of the incoming transfer
   always_comb begin
      case (req_payload.op)
         OP_START: dispatch_target = S_START;
         OP_BUMP:  dispatch_target = S_PREP;
         OP_END:   dispatch_target = S_END;
         default:  dispatch_target = S_NOP;
      endcase
   end

   // evaluate the jump condition of the current word
   always_comb begin
      case (ctl.cond)
         C_ALWAYS:    cond_true = 1'b1;
         C_DISPATCH:  cond_true = 1'b1;
         C_SKIP_BUMP: cond_true = aborted_ff || (filled_ff >= lim);
         C_ABORTED:   cond_true = aborted_ff;
         C_FILL_DONE: cond_true = slot_ctr_ff > lim;
         default:     cond_true = 1'b1;
      endcase
   end

   // advance the step counter unless the step waits
   always_comb begin
      if (hold) begin
         step_in = step_ff;
      end else if (ctl.cond == C_DISPATCH) begin
         step_in = dispatch_target;
      end else begin
         step_in = cond_true ? ctl.jmp_t : ctl.jmp_f;
      end
   end

   // datapath actions of each step
   always_comb begin
      req_in      = req_ff;
      prod_in     = prod_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      filled_in   = filled_ff;
      aborted_in  = aborted_ff;
      slot_ctr_in = slot_ctr_ff;
      rsp_in      = rsp_ff;
      fire        = 1'b0;
      if (!hold) begin
         case (ctl.act)
            A_ACCEPT: begin
               req_in = req_payload;
            end
            A_PITCH: begin
               filled_in  = 4'd0;
               aborted_in = 1'b0;
               rsp_in     = '{4'd0, {6'd0, req_ff.pitch_hz}, POWER_FLOOR, ST_PITCH, 4'd0,
                              1'b1};
               fire       = 1'b1;
            end
            A_PREP: begin
               prod_in = 32'(req_ff.bump_distance) * 32'(bin_res_ff);
               lo_in   = rng.lo;
               hi_in   = rng.hi;
            end
            A_CLASSIFY: begin
               if (freq > lo_ff) begin
                  fire = 1'b1;
                  if (freq >= hi_ff) begin
                     filled_in = next_slot;
                     rsp_in    = '{next_slot, 20'd0, POWER_FLOOR, ST_NOT_AVAIL, next_slot,
                                   1'b1};
                  end else if (req_ff.bump_amplitude[15]) begin
                     aborted_in = 1'b1;
                     rsp_in     = '{next_slot, freq, POWER_FLOOR, ST_MAG_ERROR, filled_ff,
                                    1'b1};
                  end else begin
                     filled_in = next_slot;
                     rsp_in    = '{next_slot, freq, power, ST_FOUND, next_slot, 1'b1};
                  end
               end
            end
            A_LOOP_INIT: begin
               slot_ctr_in = next_slot;
            end
            A_FILL: begin
               fire = 1'b1;
               if (slot_ctr_ff > lim) begin
                  rsp_in = '{4'd0, 20'd0, POWER_FLOOR, ST_DONE, filled_ff, 1'b1};
               end else begin
                  rsp_in      = '{slot_ctr_ff, 20'd0, POWER_FLOOR, ST_UNDEFINED, filled_ff,
                                  1'b0};
                  slot_ctr_in = slot_ctr_ff + 4'd1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // load the output register on an emit, drop valid after the transfer
   assign rsp_valid_in = fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // control state and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff         <= S_FETCH;
         filled_ff       <= 4'd0;
         aborted_ff      <= 1'b0;
         slot_ctr_ff     <= 4'd0;
         rsp_valid_ff    <= 1'b0;
         source_class_ff <= SOURCE_CLASS_RESET;
         bin_res_ff      <= BIN_RESOLUTION_RESET;
         max_formants_ff <= MAX_FORMANTS_RESET;
      end else begin
         step_ff      <= step_in;
         filled_ff    <= filled_in;
         aborted_ff   <= aborted_in;
         slot_ctr_ff  <= slot_ctr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_SOURCE_CLASS:   source_class_ff <= csr_wdata[2:0];
               CSR_BIN_RESOLUTION: bin_res_ff      <= csr_wdata;
               CSR_MAX_FORMANTS:   max_formants_ff <= csr_wdata[3:0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      prod_ff <= prod_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      rsp_ff  <= rsp_in;
   end

   assign req_ready   = (ctl.act == A_ACCEPT);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // the fill count never passes the slot cap
   assert property (@(posedge clock) disable iff (reset) filled_ff <= SLOT_CAP)
      else $error("filled slot count above cap");

   // an aborted frame never reaches the fill loop
   assert property (@(posedge clock) disable iff (reset) (step_ff == S_FILL) |-> !aborted_ff)
      else $error("fill loop entered on aborted frame");

   // only undefined results leave last low
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid_ff && (rsp_ff.status != ST_UNDEFINED)) |-> rsp_ff.last)
      else $error("final result without last");

   // the fill loop stays within one slot past the cap
   assert property (@(posedge clock) disable iff (reset)
                    (step_ff == S_FILL) |-> (slot_ctr_ff <= SLOT_CAP + 4'd1))
      else $error("fill slot counter out of range");

endmodule
